// ===== rtl/fragment_reassembly_table_macros.svh =====
// ----------------------------------------------------------------------------
// fragment reassembly table assertion macros
// shared property shapes for the block's concurrent checks
// ----------------------------------------------------------------------------
`ifndef FRAGMENT_REASSEMBLY_TABLE_MACROS_SVH
`define FRAGMENT_REASSEMBLY_TABLE_MACROS_SVH

// condition implies check in the same cycle
`define FRT_ASSERT_NOW(label, cond, chk, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (chk)) \
        else $error(msg);

// condition implies check in the next cycle
`define FRT_ASSERT_NEXT(label, cond, chk, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (chk)) \
        else $error(msg);

`endif

// ===== rtl/frt_pkg.sv =====
// ----------------------------------------------------------------------------
// frt_pkg
// types, constants and helpers shared by the fragment reassembly table
// ----------------------------------------------------------------------------
package frt_pkg;

    // default table geometry
    localparam int MAX_PAGES_DEF      = 8;
    localparam int MAX_FRAGMENTS_DEF  = 16;
    localparam int FRAGMENT_BYTES_DEF = 4;

    // field widths
    localparam int ID_W     = 16;
    localparam int NUM_W    = 5;
    localparam int ADR_W    = 16;
    localparam int DATA_W   = 32;
    localparam int NB_W     = 3;
    localparam int PBYTES_W = 7;
    localparam int STORE_W  = NB_W + DATA_W;

    // page length saturation point
    localparam logic [PBYTES_W-1:0] PBYTES_MAX = 7'd127;

    // one input word
    typedef struct packed {
        logic [ID_W-1:0]   page_id;
        logic [NUM_W-1:0]  frag_number;
        logic [NUM_W-1:0]  frag_total;
        logic [ADR_W-1:0]  source_addr;
        logic [ADR_W-1:0]  dest_addr;
        logic [DATA_W-1:0] frag_data;
        logic [NB_W-1:0]   frag_bytes;
    } frag_t;

    // one output word
    typedef struct packed {
        logic [ID_W-1:0]     out_page_id;
        logic [ADR_W-1:0]    out_source;
        logic [ADR_W-1:0]    out_dest;
        logic [DATA_W-1:0]   chunk_data;
        logic [NB_W-1:0]     chunk_bytes;
        logic [PBYTES_W-1:0] page_bytes;
        logic                last_chunk;
        logic                dropped;
    } result_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_WRITE,
        S_FETCH,
        S_SHOW
    } frt_state_t;

    // keep only the low nb bytes of a data word
    function automatic logic [DATA_W-1:0] byte_mask(input logic [NB_W-1:0] nb);
        logic [DATA_W-1:0] m;
        case (nb)
            3'd0:    m = 32'h0000_0000;
            3'd1:    m = 32'h0000_00FF;
            3'd2:    m = 32'h0000_FFFF;
            3'd3:    m = 32'h00FF_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/fragment_reassembly_table.sv =====
// ----------------------------------------------------------------------------
// fragment_reassembly_table
// collects page fragments into a table and emits each page in order
// ----------------------------------------------------------------------------
//  channel | handshake             | word
//  --------+-----------------------+----------------------------------
//  frag    | in_valid / in_ready   | frt_pkg::frag_t, one fragment
//  result  | out_valid / out_ready | frt_pkg::result_t, one chunk/drop
//
//  a fragment is held through accept, lookup with store read and write; one
//  that completes a page adds a fetch step and then an emit step per chunk;
//  a single fragment page, a drop or a bad fragment ends after its lookup
//  reset clears the entry valid bits at once, no clearing pass
//  a stalled result holds the lookup or the emit sequence; a new fragment is
//  taken while the last result still waits in the output register
// ----------------------------------------------------------------------------
`include "fragment_reassembly_table_macros.svh"

module fragment_reassembly_table #(
    parameter int MAX_PAGES      = frt_pkg::MAX_PAGES_DEF,
    parameter int MAX_FRAGMENTS  = frt_pkg::MAX_FRAGMENTS_DEF,
    parameter int FRAGMENT_BYTES = frt_pkg::FRAGMENT_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  frt_pkg::frag_t    frag,
    output logic              out_valid,
    input  logic              out_ready,
    output frt_pkg::result_t  result
);

    localparam int PAGE_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int SLOT_W = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
    localparam int CNT_W  = $clog2(MAX_FRAGMENTS + 1);
    localparam int DEPTH  = MAX_PAGES * MAX_FRAGMENTS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_W  = $clog2(MAX_FRAGMENTS * FRAGMENT_BYTES + 1);
    localparam int SAT_W  = (SUM_W > frt_pkg::PBYTES_W) ? SUM_W : frt_pkg::PBYTES_W;

    // sequencer and held fragment
    frt_pkg::frt_state_t state_reg, state_next;
    frt_pkg::frag_t      in_reg, in_next;
    logic [PAGE_W-1:0]   e_reg, e_next;
    logic [CNT_W-1:0]    s_reg, s_next;

    // entry table
    logic [MAX_PAGES-1:0]          valid_reg;
    logic [frt_pkg::ID_W-1:0]      pid_reg    [MAX_PAGES];
    logic [CNT_W-1:0]              total_reg  [MAX_PAGES];
    logic [CNT_W-1:0]              count_reg  [MAX_PAGES];
    logic [2*frt_pkg::ADR_W-1:0]   addr_reg   [MAX_PAGES];
    logic [MAX_FRAGMENTS-1:0]      filled_reg [MAX_PAGES];
    logic [SUM_W-1:0]              sum_reg    [MAX_PAGES];

    // output register
    logic              out_valid_reg;
    frt_pkg::result_t  out_reg, out_next;
    logic              out_load;
    logic              can_load;

    // fragment store
    logic                        ram_we;
    logic [ADDR_W-1:0]           ram_waddr;
    logic [frt_pkg::STORE_W-1:0] ram_wdata;
    logic                        ram_re;
    logic [ADDR_W-1:0]           ram_raddr;
    logic [frt_pkg::STORE_W-1:0] ram_rdata;

    // lookup and update control
    logic                     in_accept;
    logic                     hit, free_any;
    logic [PAGE_W-1:0]        hit_idx, free_idx;
    logic                     bad_hit, new_bad, single;
    logic [SLOT_W-1:0]        slot;
    logic                     alloc, upd;
    logic                     old_filled;
    logic [CNT_W-1:0]         count_inc;
    logic                     write_complete;
    logic [SUM_W-1:0]         sum_new;
    logic [CNT_W-1:0]         s_plus;
    logic                     show_last;
    logic [SAT_W-1:0]         sum_ext;
    logic [frt_pkg::PBYTES_W-1:0] page_len;
    logic [frt_pkg::NB_W-1:0] nb_sat;
    frt_pkg::result_t         res_direct, res_chunk;

    // state decodes and current entry fields for the checks
    logic                     st_idle, st_write, st_show;
    logic [CNT_W-1:0]         cur_count, cur_total;

    // store address of one slot of one entry
    function automatic logic [ADDR_W-1:0] addr_of(input logic [PAGE_W-1:0] e,
                                                  input logic [SLOT_W-1:0] s);
        return ADDR_W'(int'(e) * MAX_FRAGMENTS + int'(s));
    endfunction

    frt_ram #(
        .WIDTH (frt_pkg::STORE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_accept = in_valid && in_ready;
    assign can_load  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign result    = out_reg;

    // byte count saturation and data cleanup on entry
    always_comb
    begin
        nb_sat  = (frag.frag_bytes > FRAGMENT_BYTES) ? frt_pkg::NB_W'(FRAGMENT_BYTES)
                                                     : frag.frag_bytes;
        in_next = frag;
        in_next.frag_bytes = nb_sat;
        in_next.frag_data  = frag.frag_data & frt_pkg::byte_mask(nb_sat);
    end

    // page id match and lowest free entry
    always_comb
    begin
        hit      = 1'b0;
        hit_idx  = '0;
        free_any = 1'b0;
        free_idx = '0;
        for (int i = MAX_PAGES - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && (pid_reg[i] == in_reg.page_id))
            begin
                hit     = 1'b1;
                hit_idx = PAGE_W'(i);
            end
            if (!valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = PAGE_W'(i);
            end
        end
    end

    // fragment checks
    assign slot    = SLOT_W'(in_reg.frag_number - 5'd1);
    assign bad_hit = (in_reg.frag_number == '0) || (in_reg.frag_number > total_reg[hit_idx]);
    assign new_bad = (in_reg.frag_total == '0) || (in_reg.frag_total > MAX_FRAGMENTS) ||
                     (in_reg.frag_number == '0) || (in_reg.frag_number > in_reg.frag_total);
    assign single  = (in_reg.frag_total == 5'd1);

    // read-modify-write of the entry counters
    assign old_filled     = filled_reg[e_reg][slot];
    assign count_inc      = count_reg[e_reg] + (old_filled ? CNT_W'(0) : CNT_W'(1));
    assign write_complete = (count_inc >= total_reg[e_reg]);
    assign sum_new        = sum_reg[e_reg]
                          - (old_filled ? SUM_W'(ram_rdata[frt_pkg::STORE_W-1:frt_pkg::DATA_W])
                                        : SUM_W'(0))
                          + SUM_W'(in_reg.frag_bytes);

    // emit position
    assign s_plus    = s_reg + CNT_W'(1);
    assign show_last = (s_plus == total_reg[e_reg]);
    assign sum_ext   = SAT_W'(sum_reg[e_reg]);
    assign page_len  = (sum_ext > SAT_W'(frt_pkg::PBYTES_MAX)) ? frt_pkg::PBYTES_MAX
                                                               : sum_ext[frt_pkg::PBYTES_W-1:0];

    // result built straight from the held fragment
    always_comb
    begin
        res_direct.out_page_id = in_reg.page_id;
        res_direct.out_source  = in_reg.source_addr;
        res_direct.out_dest    = in_reg.dest_addr;
        res_direct.chunk_data  = in_reg.frag_data;
        res_direct.chunk_bytes = in_reg.frag_bytes;
        res_direct.page_bytes  = single ? frt_pkg::PBYTES_W'(in_reg.frag_bytes)
                                        : frt_pkg::PBYTES_W'(0);
        res_direct.last_chunk  = 1'b1;
        res_direct.dropped     = !single;
    end

    // result built from the store
    always_comb
    begin
        res_chunk.out_page_id = pid_reg[e_reg];
        res_chunk.out_source  = addr_reg[e_reg][2*frt_pkg::ADR_W-1:frt_pkg::ADR_W];
        res_chunk.out_dest    = addr_reg[e_reg][frt_pkg::ADR_W-1:0];
        res_chunk.chunk_data  = ram_rdata[frt_pkg::DATA_W-1:0];
        res_chunk.chunk_bytes = ram_rdata[frt_pkg::STORE_W-1:frt_pkg::DATA_W];
        res_chunk.page_bytes  = page_len;
        res_chunk.last_chunk  = show_last;
        res_chunk.dropped     = 1'b0;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            frt_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = frt_pkg::S_LOOKUP;
                end
            end
            frt_pkg::S_LOOKUP:
            begin
                if (hit)
                begin
                    state_next = bad_hit ? frt_pkg::S_IDLE : frt_pkg::S_WRITE;
                end
                else if (new_bad)
                begin
                    state_next = frt_pkg::S_IDLE;
                end
                else if (single || !free_any)
                begin
                    if (can_load)
                    begin
                        state_next = frt_pkg::S_IDLE;
                    end
                end
                else
                begin
                    state_next = frt_pkg::S_WRITE;
                end
            end
            frt_pkg::S_WRITE:
            begin
                state_next = write_complete ? frt_pkg::S_FETCH : frt_pkg::S_IDLE;
            end
            frt_pkg::S_FETCH:
            begin
                state_next = frt_pkg::S_SHOW;
            end
            frt_pkg::S_SHOW:
            begin
                if (can_load && show_last)
                begin
                    state_next = frt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = frt_pkg::S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready  = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = addr_of(e_reg, slot);
        ram_we    = 1'b0;
        ram_waddr = addr_of(e_reg, slot);
        ram_wdata = {in_reg.frag_bytes, in_reg.frag_data};
        out_load  = 1'b0;
        out_next  = out_reg;
        alloc     = 1'b0;
        upd       = 1'b0;
        e_next    = e_reg;
        s_next    = s_reg;
        case (state_reg)
            frt_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
            end
            frt_pkg::S_LOOKUP:
            begin
                if (hit)
                begin
                    if (!bad_hit)
                    begin
                        e_next    = hit_idx;
                        ram_re    = 1'b1;
                        ram_raddr = addr_of(hit_idx, slot);
                    end
                end
                else if (!new_bad)
                begin
                    if (single || !free_any)
                    begin
                        if (can_load)
                        begin
                            out_load = 1'b1;
                            out_next = res_direct;
                        end
                    end
                    else
                    begin
                        alloc     = 1'b1;
                        e_next    = free_idx;
                        ram_re    = 1'b1;
                        ram_raddr = addr_of(free_idx, slot);
                    end
                end
            end
            frt_pkg::S_WRITE:
            begin
                ram_we = 1'b1;
                upd    = 1'b1;
                s_next = '0;
            end
            frt_pkg::S_FETCH:
            begin
                ram_re    = 1'b1;
                ram_raddr = addr_of(e_reg, SLOT_W'(0));
            end
            frt_pkg::S_SHOW:
            begin
                if (can_load)
                begin
                    out_load = 1'b1;
                    out_next = res_chunk;
                    if (!show_last)
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = addr_of(e_reg, s_plus[SLOT_W-1:0]);
                        s_next    = s_plus;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= frt_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (alloc)
            begin
                valid_reg[free_idx] <= 1'b1;
            end
            else if (upd && write_complete)
            begin
                valid_reg[e_reg] <= 1'b0;
            end
        end
    end

    // payload registers and entry contents
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_reg <= in_next;
        end
        e_reg <= e_next;
        s_reg <= s_next;
        if (out_load)
        begin
            out_reg <= out_next;
        end
        if (alloc)
        begin
            pid_reg[free_idx]    <= in_reg.page_id;
            total_reg[free_idx]  <= CNT_W'(in_reg.frag_total);
            count_reg[free_idx]  <= '0;
            addr_reg[free_idx]   <= {in_reg.source_addr, in_reg.dest_addr};
            filled_reg[free_idx] <= '0;
            sum_reg[free_idx]    <= '0;
        end
        if (upd)
        begin
            sum_reg[e_reg] <= sum_new;
            if (write_complete)
            begin
                filled_reg[e_reg] <= '0;
                count_reg[e_reg]  <= '0;
            end
            else
            begin
                filled_reg[e_reg][slot] <= 1'b1;
                count_reg[e_reg]        <= count_inc;
            end
        end
    end

    // decodes used by the checks
    assign st_idle   = (state_reg == frt_pkg::S_IDLE);
    assign st_write  = (state_reg == frt_pkg::S_WRITE);
    assign st_show   = (state_reg == frt_pkg::S_SHOW);
    assign cur_count = count_reg[e_reg];
    assign cur_total = total_reg[e_reg];

    // checks
    `FRT_ASSERT_NOW(a_count_below_total, st_write, cur_count < cur_total, "entry already full")
    `FRT_ASSERT_NEXT(a_entry_freed, st_write && write_complete, !valid_reg[e_reg], "not freed")
    `FRT_ASSERT_NOW(a_emit_in_range, st_show, s_reg < cur_total, "emit beyond page total")
    `FRT_ASSERT_NEXT(a_last_ends_run, out_load && out_next.last_chunk, st_idle, "busy after last")

endmodule

// ===== rtl/frt_ram.sv =====
// ----------------------------------------------------------------------------
// frt_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module frt_ram #(
    parameter int WIDTH = frt_pkg::STORE_W,
    parameter int DEPTH = frt_pkg::MAX_PAGES_DEF * frt_pkg::MAX_FRAGMENTS_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, holds its data while no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== dv/tb_fragment_reassembly_table.sv =====
// ----------------------------------------------------------------------------
// tb_fragment_reassembly_table
// checks the fragment reassembly table against a cycle-free page predictor:
// a directed pass over single-word pages, bad numbers and totals, duplicates,
// header rules and a full table, then random interleaved pages with noise,
// run under three sender/receiver idle mixes
// ----------------------------------------------------------------------------
module tb_fragment_reassembly_table;

    localparam int NPAGES         = frt_pkg::MAX_PAGES_DEF;
    localparam int NFRAGS         = frt_pkg::MAX_FRAGMENTS_DEF;
    localparam int FBYTES         = frt_pkg::FRAGMENT_BYTES_DEF;
    localparam int ID_W           = frt_pkg::ID_W;
    localparam int NUM_W          = frt_pkg::NUM_W;
    localparam int ADR_W          = frt_pkg::ADR_W;
    localparam int DATA_W         = frt_pkg::DATA_W;
    localparam int NB_W           = frt_pkg::NB_W;
    localparam int PBYTES_W       = frt_pkg::PBYTES_W;
    localparam int RANDOM_ITEMS   = 300;
    localparam int PHASE_ITEMS    = 100;
    localparam int OPEN_MAX       = 10;
    localparam int HOLD_CYCLES    = 8;
    localparam int TAIL_CYCLES    = 20;
    localparam int CYCLE_LIMIT    = 400000;
    localparam logic [15:0] OPEN_FULL = 16'((1 << OPEN_MAX) - 1);

    // kinds of off-pattern fragments mixed into the random part
    typedef enum int {
        NOISE_BAD_TOTAL,
        NOISE_BAD_NUMBER,
        NOISE_DUPLICATE,
        NOISE_SINGLE
    } noise_kind_t;

    // page predictor and the queue of result words it owes
    class reassembly_scoreboard;
        frt_pkg::result_t  chunks_due[$];
        bit                busy[NPAGES];
        logic [ID_W-1:0]   page_of[NPAGES];
        int                count_of[NPAGES];
        logic [NUM_W-1:0]  total_of[NPAGES];
        logic [ADR_W-1:0]  src_of[NPAGES];
        logic [ADR_W-1:0]  dst_of[NPAGES];
        logic [NFRAGS-1:0] filled[NPAGES];
        logic [DATA_W-1:0] data_of[NPAGES][NFRAGS];
        logic [NB_W-1:0]   nb_of[NPAGES][NFRAGS];
        logic [ID_W-1:0]   cur_id;
        int errors;
        int checked;
        int pages_done;
        int singles;
        int drops;

        function new();
            int i;
            for (i = 0; i < NPAGES; i++)
                busy[i] = 1'b0;
            errors = 0;
            checked = 0;
            pages_done = 0;
            singles = 0;
            drops = 0;
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        function int pending();
            return chunks_due.size();
        endfunction

        // append one owed word at the tail of the queue
        function void owe(frt_pkg::result_t r);
            chunks_due.insert(chunks_due.size(), r);
        endfunction

        // low nb bytes kept, the rest cleared
        function logic [DATA_W-1:0] keep_mask(logic [NB_W-1:0] nb);
            if (nb >= NB_W'(4))
                return '1;
            return (32'h1 << (8 * nb)) - 32'h1;
        endfunction

        // predict the words caused by one accepted fragment, 1 if it is dropped
        function bit take_fragment(frt_pkg::frag_t f);
            logic [NB_W-1:0]   nb;
            logic [DATA_W-1:0] data;
            frt_pkg::result_t  r;
            int                e;
            int                i;
            int                s;
            int                sum;
            nb   = (f.frag_bytes > NB_W'(FBYTES)) ? NB_W'(FBYTES) : f.frag_bytes;
            data = f.frag_data & keep_mask(nb);
            e    = -1;
            for (i = 0; i < NPAGES; i++)
                if (e < 0 && busy[i] && page_of[i] == f.page_id)
                    e = i;

            // new page: check header, single-word page, allocation
            if (e < 0)
            begin
                if (f.frag_total == 0 || f.frag_total > NFRAGS ||
                    f.frag_number == 0 || f.frag_number > f.frag_total)
                    return 1'b0;
                r             = '0;
                r.out_page_id = f.page_id;
                r.out_source  = f.source_addr;
                r.out_dest    = f.dest_addr;
                r.chunk_data  = data;
                r.chunk_bytes = nb;
                r.last_chunk  = 1'b1;
                if (f.frag_total == 1)
                begin
                    r.page_bytes = PBYTES_W'(nb);
                    owe(r);
                    singles++;
                    return 1'b0;
                end
                for (i = 0; i < NPAGES; i++)
                    if (e < 0 && !busy[i])
                        e = i;
                if (e < 0)
                begin
                    r.dropped = 1'b1;
                    owe(r);
                    drops++;
                    return 1'b1;
                end
                busy[e]     = 1'b1;
                page_of[e]  = f.page_id;
                count_of[e] = 0;
                total_of[e] = f.frag_total;
                src_of[e]   = f.source_addr;
                dst_of[e]   = f.dest_addr;
                filled[e]   = '0;
            end
            else if (f.frag_number == 0 || f.frag_number > total_of[e])
            begin
                return 1'b0;
            end

            // store the slot, count it once
            s = f.frag_number - 1;
            data_of[e][s] = data;
            nb_of[e][s]   = nb;
            if (!filled[e][s])
            begin
                filled[e][s] = 1'b1;
                count_of[e]++;
            end

            // page complete: emit in slot order and free the entry
            if (count_of[e] >= total_of[e])
            begin
                sum = 0;
                for (i = 0; i < total_of[e]; i++)
                    sum += nb_of[e][i];
                if (sum > frt_pkg::PBYTES_MAX)
                    sum = frt_pkg::PBYTES_MAX;
                for (i = 0; i < total_of[e]; i++)
                begin
                    r             = '0;
                    r.out_page_id = page_of[e];
                    r.out_source  = src_of[e];
                    r.out_dest    = dst_of[e];
                    r.chunk_data  = data_of[e][i];
                    r.chunk_bytes = nb_of[e][i];
                    r.page_bytes  = PBYTES_W'(sum);
                    r.last_chunk  = (i == total_of[e] - 1);
                    owe(r);
                end
                busy[e] = 1'b0;
                pages_done++;
            end
            return 1'b0;
        endfunction

        task cmp(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("page %h: %s is %h, expected %h",
                                 cur_id, name, got, want));
        endtask

        // compare one accepted result word with the oldest prediction
        task check_chunk(frt_pkg::result_t got);
            frt_pkg::result_t want;
            if (chunks_due.size() == 0)
            begin
                report($sformatf("result word for page %h with nothing owed",
                                 got.out_page_id));
                return;
            end
            want   = chunks_due.pop_front();
            cur_id = want.out_page_id;
            checked++;
            cmp("out_page_id", 32'(got.out_page_id), 32'(want.out_page_id));
            cmp("out_source", 32'(got.out_source), 32'(want.out_source));
            cmp("out_dest", 32'(got.out_dest), 32'(want.out_dest));
            cmp("chunk_data", got.chunk_data, want.chunk_data);
            cmp("chunk_bytes", 32'(got.chunk_bytes), 32'(want.chunk_bytes));
            cmp("page_bytes", 32'(got.page_bytes), 32'(want.page_bytes));
            cmp("last_chunk", 32'(got.last_chunk), 32'(want.last_chunk));
            cmp("dropped", 32'(got.dropped), 32'(want.dropped));
        endtask
    endclass

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    frt_pkg::frag_t   frag;
    logic             out_valid;
    logic             out_ready;
    frt_pkg::result_t result;

    reassembly_scoreboard sb;

    int send_idle;
    int recv_idle;
    int send_idle_by_phase[3] = '{14, 83, 0};
    int recv_idle_by_phase[3] = '{83, 14, 0};
    int items_sent;
    int cycles;

    // pages the random generator is in the middle of sending
    logic [ID_W-1:0]   open_pid[OPEN_MAX];
    logic [NUM_W-1:0]  open_total[OPEN_MAX];
    logic [ADR_W-1:0]  open_src[OPEN_MAX];
    logic [ADR_W-1:0]  open_dst[OPEN_MAX];
    logic [NFRAGS-1:0] open_todo[OPEN_MAX];
    logic [NFRAGS-1:0] open_sent[OPEN_MAX];
    logic [15:0]       open_live;

    fragment_reassembly_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .frag      (frag),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // cycle watchdog
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("run stopped at the cycle limit of %0d", CYCLE_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // receiver back-pressure
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_chunk(result);
    end

    function automatic frt_pkg::frag_t make_frag(logic [ID_W-1:0] pid,
                                                 logic [NUM_W-1:0] num,
                                                 logic [NUM_W-1:0] tot,
                                                 logic [ADR_W-1:0] src,
                                                 logic [ADR_W-1:0] dst,
                                                 logic [DATA_W-1:0] data,
                                                 logic [NB_W-1:0] nb);
        frt_pkg::frag_t f;
        f.page_id     = pid;
        f.frag_number = num;
        f.frag_total  = tot;
        f.source_addr = src;
        f.dest_addr   = dst;
        f.frag_data   = data;
        f.frag_bytes  = nb;
        return f;
    endfunction

    function automatic frt_pkg::frag_t rand_frag();
        frt_pkg::frag_t f;
        int             k;
        k = $urandom_range(99);
        f.page_id     = ID_W'($urandom);
        f.frag_number = NUM_W'($urandom);
        f.frag_total  = NUM_W'($urandom);
        f.source_addr = ADR_W'($urandom);
        f.dest_addr   = ADR_W'($urandom);
        f.frag_data   = $urandom;
        if (k < 85)
            f.frag_bytes = NB_W'($urandom_range(4, 1));
        else if (k < 90)
            f.frag_bytes = '0;
        else
            f.frag_bytes = NB_W'($urandom_range(7, 5));
        return f;
    endfunction

    // random index of a set bit, -1 when none
    function automatic int pick_one(logic [15:0] mask);
        int start;
        int k;
        int idx;
        idx   = -1;
        start = $urandom_range(15);
        for (k = 0; k < 16; k++)
            if (idx < 0 && mask[(start + k) % 16])
                idx = (start + k) % 16;
        return idx;
    endfunction

    // present one fragment word and hold it until accepted; entered and left at negedge
    task automatic send_frag(input frt_pkg::frag_t f, output bit was_drop);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        frag     <= f;
        do
            @(posedge clk);
        while (!in_ready);
        was_drop = sb.take_fragment(f);
        items_sent++;
        @(negedge clk);
    endtask

    // sender holds off until every owed word has come back
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (HOLD_CYCLES) @(negedge clk);
    endtask

    // one random word: a fragment of an open page, or noise
    task automatic random_item(input bit fresh_ok, output bit counted);
        int               s;
        int               idx;
        int               k;
        bit               is_page;
        bit               drop;
        logic [NUM_W-1:0] tot;
        noise_kind_t      kind;
        frt_pkg::frag_t   f;
        counted = 1'b1;
        is_page = 1'b0;
        idx     = 0;
        s       = pick_one(open_live);
        f       = rand_frag();
        if (fresh_ok && $urandom_range(99) < 12)
        begin
            kind = noise_kind_t'($urandom_range(3));
            if (s < 0 && kind != NOISE_SINGLE)
                kind = NOISE_BAD_TOTAL;
            else if (kind == NOISE_DUPLICATE && open_sent[s] == '0)
                kind = NOISE_SINGLE;
            case (kind)
                NOISE_BAD_TOTAL:
                begin
                    f.frag_total = $urandom_range(1) ? '0
                                 : NUM_W'($urandom_range(31, NFRAGS + 1));
                    counted = 1'b0;
                end
                NOISE_BAD_NUMBER:
                begin
                    f.page_id     = open_pid[s];
                    f.frag_total  = open_total[s];
                    f.frag_number = $urandom_range(1) ? '0 :
                                    NUM_W'($urandom_range(31, open_total[s] + 1));
                    counted = 1'b0;
                end
                NOISE_DUPLICATE:
                begin
                    f.page_id     = open_pid[s];
                    f.frag_total  = open_total[s];
                    f.frag_number = NUM_W'(pick_one(open_sent[s]) + 1);
                end
                default:
                begin
                    f.frag_number = NUM_W'(1);
                    f.frag_total  = NUM_W'(1);
                end
            endcase
        end
        else
        begin
            // open a new page now and then, mostly small ones
            if (fresh_ok && open_live != OPEN_FULL && (s < 0 || $urandom_range(99) < 30))
            begin
                s = pick_one(~open_live & OPEN_FULL);
                k = $urandom_range(99);
                if (k < 15)
                    tot = NUM_W'(1);
                else if (k < 75)
                    tot = NUM_W'($urandom_range(5, 2));
                else if (k < 95)
                    tot = NUM_W'($urandom_range(15, 6));
                else
                    tot = NUM_W'(NFRAGS);
                open_pid[s]   = ID_W'($urandom);
                open_total[s] = tot;
                open_src[s]   = ADR_W'($urandom);
                open_dst[s]   = ADR_W'($urandom);
                open_todo[s]  = NFRAGS'((17'h1 << tot) - 17'h1);
                open_sent[s]  = '0;
                open_live[s]  = 1'b1;
            end
            if (s < 0)
            begin
                counted = 1'b0;
                return;
            end
            is_page       = 1'b1;
            idx           = pick_one(open_todo[s]);
            f.page_id     = open_pid[s];
            f.frag_number = NUM_W'(idx + 1);
            // once the entry exists, later headers sometimes disagree
            if (open_sent[s] == '0 || $urandom_range(4) != 0)
            begin
                f.frag_total  = open_total[s];
                f.source_addr = open_src[s];
                f.dest_addr   = open_dst[s];
            end
        end
        send_frag(f, drop);
        // a dropped fragment is sent again later
        if (is_page && !drop)
        begin
            open_todo[s][idx] = 1'b0;
            open_sent[s][idx] = 1'b1;
            if (open_todo[s] == '0)
                open_live[s] = 1'b0;
        end
    endtask

    // main sequence
    initial
    begin
        int i;
        int phase;
        int random_done;
        int guard;
        bit drop;
        bit counted;
        sb         = new();
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        frag       = '0;
        items_sent = 0;
        open_live  = '0;
        phase      = 0;
        send_idle  = send_idle_by_phase[0];
        recv_idle  = recv_idle_by_phase[0];
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // single-word pages at the field extremes, byte count saturated and zero
        send_frag(make_frag(16'h0000, 5'd1, 5'd1, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF,
                            3'd7), drop);
        send_frag(make_frag(16'hFFFF, 5'd1, 5'd1, 16'h0000, 16'hFFFF, 32'hA5A5_A5A5,
                            3'd0), drop);
        // bad totals and bad numbers on a new page leave no trace
        send_frag(make_frag(16'h0BAD, 5'd1, 5'd0, 16'h1234, 16'h5678, 32'h1111_1111,
                            3'd4), drop);
        send_frag(make_frag(16'h0BAD, 5'd31, 5'd31, 16'h1234, 16'h5678, 32'h2222_2222,
                            3'd4), drop);
        send_frag(make_frag(16'h0BAD, 5'd0, 5'd3, 16'h1234, 16'h5678, 32'h3333_3333,
                            3'd4), drop);
        send_frag(make_frag(16'h0BAD, 5'd4, 5'd3, 16'h1234, 16'h5678, 32'h4444_4444,
                            3'd4), drop);
        // open a three-word page, then overwrite its slot with a duplicate
        send_frag(make_frag(16'h1234, 5'd2, 5'd3, 16'h1111, 16'h2222, 32'h0403_0201,
                            3'd1), drop);
        send_frag(make_frag(16'h1234, 5'd2, 5'd3, 16'h1111, 16'h2222, 32'h0807_0605,
                            3'd2), drop);
        // fill the rest of the table
        for (i = 0; i < NPAGES - 1; i++)
            send_frag(make_frag(ID_W'(16'h0100 + i), 5'd1, 5'd2, ADR_W'($urandom),
                                ADR_W'($urandom), $urandom, 3'd3), drop);
        // full table: a new page drops, a single-word page still goes through
        send_frag(make_frag(16'h0200, 5'd1, 5'd2, 16'hAAAA, 16'h5555, 32'hFFFF_FFFF,
                            3'd4), drop);
        send_frag(make_frag(16'h0201, 5'd1, 5'd1, 16'h5555, 16'hAAAA, 32'h0000_0000,
                            3'd4), drop);
        // later header is ignored, number over the stored total is ignored
        send_frag(make_frag(16'h1234, 5'd3, 5'd5, 16'h9999, 16'h8888, 32'hDEAD_BEEF,
                            3'd3), drop);
        send_frag(make_frag(16'h1234, 5'd5, 5'd5, 16'h9999, 16'h8888, 32'h0BAD_F00D,
                            3'd4), drop);
        send_frag(make_frag(16'h1234, 5'd1, 5'd3, 16'h1111, 16'h2222, 32'hCAFE_F00D,
                            3'd4), drop);
        // finish the filler pages
        for (i = 0; i < NPAGES - 1; i++)
            send_frag(make_frag(ID_W'(16'h0100 + i), 5'd2, 5'd2, ADR_W'($urandom),
                                ADR_W'($urandom), $urandom, 3'd4), drop);
        drain();

        // random interleaved pages across the three idle mixes
        random_done = 0;
        while (random_done < RANDOM_ITEMS)
        begin
            if (random_done >= (phase + 1) * PHASE_ITEMS && phase < 2)
            begin
                drain();
                phase++;
                send_idle = send_idle_by_phase[phase];
                recv_idle = recv_idle_by_phase[phase];
            end
            random_item(1'b1, counted);
            if (counted)
                random_done++;
            if ($urandom_range(59) == 0)
                drain();
        end

        // send what is left of the open pages
        guard = 0;
        while (open_live != '0 && guard < 3000)
        begin
            random_item(1'b0, counted);
            guard++;
        end

        // wait for the owed words, then a short tail
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d result words never arrived", sb.pending()));

        $display("run covered %0d fragment words over three idle mixes, %0d result words checked",
                 items_sent, sb.checked);
        $display("%0d pages rebuilt, %0d single-word pages, %0d table-full drops",
                 sb.pages_done, sb.singles, sb.drops);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
